/* hw/rtl/bbss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbss_pkg
// Request and result types, opcodes and register indexes of the balanced
// Bernoulli subset sampler.
// ----------------------------------------------------------------------------
package bbss_pkg;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_DRAW    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] CFG_ENSURE_MODE  = 2'd0;
    localparam logic [1:0] CFG_MOTIF_COUNT  = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd2;

    localparam int CFG_DATA_W = 16;
    localparam int Q16_ONE    = 65536;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  motif_index;
        logic [16:0] prob_value;
        logic [15:0] random_value;
    } bbss_req_t;

    typedef struct packed {
        logic [5:0] motif_id;
        logic       chosen;
        logic       round_end;
        logic       exhausted;
    } bbss_res_t;

endpackage

/* hw/rtl/balanced_bernoulli_subset_sampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balanced_bernoulli_subset_sampler
// Per-motif Bernoulli selection with probability rebalancing over rounds.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready with a bbss_req_t payload; results
// leave on res_valid/res_ready as bbss_res_t, one result per draw request.
// Load and restart requests complete in the cycle they are accepted.
// A draw reads the probability table (synchronous read memory) and, in
// ensure mode with more than one sample left, multiplies by the remaining
// sample count, subtracts one if the motif was chosen and divides by that
// count minus one in a restoring divider that retires one quotient bit per
// cycle (FRAC_BITS+2 steps). Such a draw goes through read, prepare, divide,
// write and emit; other draws go from read to emit, exhausted ones go to
// emit. One draw is in work at a time. The result sits in an output register;
// when the receiver stalls, a finished draw waits for that register to free
// up and no new request is taken meanwhile. Reset clears control state, the
// pointer and the sample counter and restores the register defaults; table
// entries stay undefined until loaded. Configuration is written through
// cfg_wr_en/cfg_index/cfg_data.
// ----------------------------------------------------------------------------
module balanced_bernoulli_subset_sampler
    import bbss_pkg::*;
#(
    parameter int MAX_MOTIFS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  bbss_req_t             req_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output bbss_res_t             res_data
);

    localparam int AW    = (MAX_MOTIFS > 1) ? $clog2(MAX_MOTIFS) : 1;
    localparam int CW    = ($clog2(MAX_MOTIFS + 1) > 7) ? $clog2(MAX_MOTIFS + 1) : 7;
    localparam int FW    = FRAC_BITS + 1;
    localparam int PW    = FW + 16;
    localparam int QW    = FRAC_BITS + 2;
    localparam int DCW   = $clog2(QW + 1);
    localparam int EXT_W = 34;
    localparam int SH_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SH_DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    localparam logic [FW-1:0] ONE_F = FW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] ONE_P = PW'(1) << FRAC_BITS;
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]     state_reg, state_next;
    logic           ensure_reg, ensure_next;
    logic [6:0]     mcount_reg, mcount_next;
    logic [15:0]    scount_reg, scount_next;
    logic [15:0]    samples_reg, samples_next;
    logic [AW-1:0]  ptr_reg, ptr_next;
    logic           chosen_reg, chosen_next;
    logic           last_reg, last_next;
    logic           exh_reg, exh_next;
    logic [FW-1:0]  rnd_reg, rnd_next;
    logic [PW-1:0]  prod_reg, prod_next;
    logic [15:0]    rem_reg, rem_next;
    logic [QW-1:0]  rq_reg, rq_next;
    logic [15:0]    dvs_reg, dvs_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic           res_valid_reg, res_valid_next;
    bbss_res_t      res_data_reg, res_data_next;

    logic [FW-1:0]  mem [MAX_MOTIFS];
    logic [FW-1:0]  rd_data_reg;
    logic           mem_we, mem_re;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    logic [FW-1:0]  mem_wdata;

    logic [16:0]    prob_sat;
    logic [FW-1:0]  prob_fx, rnd_fx;
    logic [CW-1:0]  cnt_eff;
    logic [AW-1:0]  ptr_fix;
    logic           draw_last;
    logic [PW-1:0]  dividend;
    logic [17:0]    trial;
    logic           out_free;

    assign prob_sat = (req_data.prob_value > 17'(Q16_ONE)) ? 17'(Q16_ONE)
                                                           : req_data.prob_value;
    assign prob_fx  = FW'((EXT_W'(prob_sat) << SH_UP) >> SH_DN);
    assign rnd_fx   = FW'((EXT_W'(req_data.random_value) << SH_UP) >> SH_DN);

    assign cnt_eff  = (mcount_reg == 7'd0) ? CW'(1) :
                      (CW'(mcount_reg) > CW'(MAX_MOTIFS)) ? CW'(MAX_MOTIFS) :
                      CW'(mcount_reg);
    assign ptr_fix   = (CW'(ptr_reg) >= cnt_eff) ? '0 : ptr_reg;
    assign draw_last = (CW'(ptr_fix) + CW'(1)) >= cnt_eff;

    assign dividend = chosen_reg ? ((prod_reg > ONE_P) ? prod_reg - ONE_P : '0)
                                 : prod_reg;
    assign trial    = {1'b0, rem_reg, rq_reg[QW-1]} - {2'b00, dvs_reg};
    assign out_free = !res_valid_reg || res_ready;

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        ensure_next    = ensure_reg;
        mcount_next    = mcount_reg;
        scount_next    = scount_reg;
        samples_next   = samples_reg;
        ptr_next       = ptr_reg;
        chosen_next    = chosen_reg;
        last_next      = last_reg;
        exh_next       = exh_reg;
        rnd_next       = rnd_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        rq_next        = rq_reg;
        dvs_next       = dvs_reg;
        dcnt_next      = dcnt_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_data_next  = res_data_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = AW'(req_data.motif_index);
        mem_raddr      = ptr_fix;
        mem_wdata      = prob_fx;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ENSURE_MODE:  ensure_next = cfg_data[0];
                CFG_MOTIF_COUNT:  mcount_next = cfg_data[6:0];
                CFG_SAMPLE_COUNT: scount_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_data.opcode)
                        OP_LOAD:
                        begin
                            mem_we = (32'(req_data.motif_index) < 32'(MAX_MOTIFS));
                        end
                        OP_RESTART:
                        begin
                            samples_next = scount_reg;
                            ptr_next     = '0;
                        end
                        OP_DRAW:
                        begin
                            ptr_next = ptr_fix;
                            rnd_next = rnd_fx;
                            if (ensure_reg && samples_reg == 16'd0)
                            begin
                                exh_next    = 1'b1;
                                chosen_next = 1'b0;
                                last_next   = 1'b0;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                exh_next   = 1'b0;
                                last_next  = draw_last;
                                mem_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ:
            begin
                chosen_next = rnd_reg < rd_data_reg;
                prod_next   = PW'(rd_data_reg) * PW'(samples_reg);
                if (ensure_reg && samples_reg > 16'd1)
                    state_next = S_PREP;
                else
                    state_next = S_EMIT;
            end
            S_PREP:
            begin
                rem_next   = 16'(dividend >> QW);
                rq_next    = dividend[QW-1:0];
                dvs_next   = samples_reg - 16'd1;
                dcnt_next  = DCW'(QW);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!trial[17])
                begin
                    rem_next = trial[15:0];
                    rq_next  = {rq_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[14:0], rq_reg[QW-1]};
                    rq_next  = {rq_reg[QW-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - DCW'(1);
                if (dcnt_reg == DCW'(1))
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg;
                mem_wdata  = (rq_reg > ONE_Q) ? ONE_F : rq_reg[FW-1:0];
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next          = 1'b1;
                    res_data_next.motif_id  = 6'(ptr_reg);
                    res_data_next.chosen    = chosen_reg;
                    res_data_next.round_end = last_reg;
                    res_data_next.exhausted = exh_reg;
                    if (!exh_reg)
                    begin
                        ptr_next = last_reg ? '0 : AW'(CW'(ptr_reg) + CW'(1));
                        if (ensure_reg && last_reg)
                            samples_next = samples_reg - 16'd1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ensure_reg    <= 1'b0;
            mcount_reg    <= 7'd64;
            scount_reg    <= 16'd1;
            samples_reg   <= '0;
            ptr_reg       <= '0;
            dcnt_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ensure_reg    <= ensure_next;
            mcount_reg    <= mcount_next;
            scount_reg    <= scount_next;
            samples_reg   <= samples_next;
            ptr_reg       <= ptr_next;
            dcnt_reg      <= dcnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chosen_reg   <= chosen_next;
        last_reg     <= last_next;
        exh_reg      <= exh_next;
        rnd_reg      <= rnd_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        rq_reg       <= rq_next;
        dvs_reg      <= dvs_next;
        res_data_reg <= res_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

endmodule

/* hw/rtl/bbss_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbss_checker
// Port-level checks on the subset sampler, bound to the top level.
// ----------------------------------------------------------------------------
module bbss_checker
    import bbss_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input bbss_req_t req_data,
    input logic      res_valid,
    input logic      res_ready,
    input bbss_res_t res_data
);

    // hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // block new requests while a draw is in work
    a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_data.opcode == OP_DRAW |=> !req_ready)
        else $error("request taken during a draw");

    // drop chosen and round end on an exhausted draw
    a_exh_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.exhausted |-> !res_data.chosen && !res_data.round_end)
        else $error("exhausted draw carries a selection");

    // issue a new result only from a busy cycle
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !$past(req_ready))
        else $error("result without a draw in work");

endmodule

bind balanced_bernoulli_subset_sampler bbss_checker u_bbss_checker (.*);
